/* rtl/core/rbls_pkg.sv */
// Shared types, constants and codes of the rigid body linear step block.
// No dependencies; every other file of the block refers to it by scoped names.
package rbls_pkg;

  // Fixed-point formats
  localparam int FIX_W      = 48;  // Q15.32 position, velocity, force
  localparam int DT_W       = 16;  // Q8.8 time step
  localparam int DAMP_W     = 16;  // Q1.15 damping
  localparam int THR_W      = 63;  // squared-speed threshold
  localparam int HALF_W     = 32;  // multiplier operand width
  localparam int PROD_W     = 2 * FIX_W;
  localparam int SUM_W      = 2 * HALF_W + 2;
  localparam int DAMP_FRAC  = 15;
  localparam int IMASS_FRAC = 32;
  localparam int DT_FRAC    = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  localparam int REST_FRAMES_DEF = 8;

  typedef logic signed [FIX_W-1:0] fix_t;
  typedef fix_t [2:0] vec_t;

  localparam fix_t FIX_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam fix_t FIX_MIN   = 48'sh8000_0000_0000;
  localparam fix_t GRAVITY_Y = -48'sd42950;

  localparam logic [FIX_W-1:0] INV_MASS_RST = 48'h0001_0000_0000;
  localparam logic [DAMP_W-1:0] DAMP_RST    = 16'd32113;
  localparam logic [THR_W-1:0] THR_RST      = 63'd184467440737;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY_ENABLE,
    REG_MOVABLE,
    REG_INVERSE_MASS,
    REG_DAMPING,
    REG_REST_THRESHOLD,
    REG_START_X,
    REG_START_Y,
    REG_START_Z
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAMP,
    ST_ACC,
    ST_DVEL,
    ST_DPOS,
    ST_PUSH,
    ST_CHK_RD,
    ST_CHK_SQ,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // Request to the shared multiplier: unsigned magnitudes
  typedef struct packed {
    logic [FIX_W-1:0] a;
    logic [FIX_W-1:0] b;
    logic             short_b;   // b below 2^32
    logic             short_ab;  // a and b below 2^32
  } mul_req_t;

endpackage

/* rtl/core/rbls_if.sv */
// Channel interfaces of the rigid body linear step block: tick input,
// result output and configuration writes. Depends on rbls_pkg.
interface rbls_tick_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic signed [rbls_pkg::FIX_W-1:0] force_x;
  logic signed [rbls_pkg::FIX_W-1:0] force_y;
  logic signed [rbls_pkg::FIX_W-1:0] force_z;
  logic [rbls_pkg::DT_W-1:0]   dt_ms;
  modport source (output valid, cmd, force_x, force_y, force_z, dt_ms, input ready);
  modport sink (input valid, cmd, force_x, force_y, force_z, dt_ms, output ready);
endinterface

interface rbls_result_if;
  logic                        valid;
  logic                        ready;
  logic signed [rbls_pkg::FIX_W-1:0] pos_x;
  logic signed [rbls_pkg::FIX_W-1:0] pos_y;
  logic signed [rbls_pkg::FIX_W-1:0] pos_z;
  logic signed [rbls_pkg::FIX_W-1:0] vel_x;
  logic signed [rbls_pkg::FIX_W-1:0] vel_y;
  logic signed [rbls_pkg::FIX_W-1:0] vel_z;
  logic                        at_rest;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, at_rest,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, at_rest,
                output ready);
endinterface

interface rbls_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rbls_pkg::CFG_IDX_W-1:0]    index;
  logic [rbls_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/rbls_mul.sv */
// Shared 48x48 unsigned multiplier built from one 32x32 multiplier that
// runs over up to four partial products and accumulates them. Uses rbls_pkg.
module rbls_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  rbls_pkg::mul_req_t            req,
  output logic [rbls_pkg::PROD_W-1:0]   prod,
  output logic                          done
);

  localparam int HW = rbls_pkg::HALF_W;
  localparam int FW = rbls_pkg::FIX_W;
  localparam int PW = rbls_pkg::PROD_W;

  logic [FW-1:0]   a;
  logic [FW-1:0]   b;
  logic [1:0]      step;
  logic [1:0]      last;
  logic            busy;
  logic [2*HW-1:0] pp;
  logic [1:0]      pp_sh;
  logic            pp_v;
  logic            pp_last;
  logic [HW-1:0]   op_a;
  logic [HW-1:0]   op_b;
  logic [PW-1:0]   pp_ext;

  // Pick the halves for this partial product: step bit 0 selects high a,
  // step bit 1 selects high b
  assign op_a = step[0] ? HW'(a[FW-1:HW]) : a[HW-1:0];
  assign op_b = step[1] ? HW'(b[FW-1:HW]) : b[HW-1:0];

  // Align the registered partial product
  always_comb begin
    case (pp_sh)
      2'd0:    pp_ext = PW'(pp);
      2'd1:    pp_ext = PW'(pp) << HW;
      default: pp_ext = PW'(pp) << (2 * HW);
    endcase
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pp_v <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= pp_v & pp_last;
      pp_v <= busy;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == last) begin
        busy <= 1'b0;
      end
    end
  end

  // Operands, partial product and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a    <= req.a;
      b    <= req.b;
      step <= 2'd0;
      prod <= '0;
      if (req.short_ab) begin
        last <= 2'd0;
      end else if (req.short_b) begin
        last <= 2'd1;
      end else begin
        last <= 2'd3;
      end
    end
    if (busy) begin
      pp      <= op_a * op_b;
      pp_sh   <= {1'b0, step[0]} + {1'b0, step[1]};
      pp_last <= (step == last);
      step    <= step + 2'd1;
    end
    if (pp_v) begin
      prod <= prod + pp_ext;
    end
  end

endmodule

/* rtl/core/rbls_win.sv */
// Window of recent velocities: a row memory written round robin, with one
// valid bit per row so that cleared rows read as zero. Uses rbls_pkg.
module rbls_win #(
  parameter int ROWS = rbls_pkg::REST_FRAMES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  logic                    push,
  input  rbls_pkg::vec_t          push_row,
  input  logic                    rd_en,
  input  logic [$clog2(ROWS)-1:0] rd_addr,
  output rbls_pkg::vec_t          rd_row
);

  localparam int AW = $clog2(ROWS);

  rbls_pkg::vec_t mem [ROWS];
  rbls_pkg::vec_t rd_data;
  logic           rd_hit;
  logic [ROWS-1:0] valid;
  logic [AW-1:0]  ptr;

  // Write the newest row over the oldest one
  always_ff @(posedge clk) begin
    if (push) begin
      mem[ptr] <= push_row;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Valid bits, write pointer and read hit
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid  <= '0;
      ptr    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
      if (push) begin
        valid[ptr] <= 1'b1;
        ptr        <= (ptr == AW'(ROWS - 1)) ? '0 : ptr + 1'b1;
      end
    end
  end

  assign rd_row = rd_hit ? rd_data : '0;

endmodule

/* rtl/core/rigid_body_linear_step.sv */
// Rigid body linear step: semi-implicit Euler update of one body.
// Channels: cfg writes a register (index, data) and is always ready; the user
// must write it only while the block is idle; the block does not enforce it.
// tick carries cmd, force and dt_ms; result returns position, velocity and
// at_rest for each tick. The block takes one tick at a time: tick.ready is
// high only when no item is in work. All products go through one shared
// 32x32 multiplier. A movable body runs damping, then acceleration, velocity
// and position updates per component, then the rest test over the window
// rows, which ends early when a row fails it; a fixed body runs damping only,
// and a restart involves no multiplication.
// The block returns to idle and tick.ready rises at the edge that loads the
// result register.
// A finished result sits in the output register until result.ready; the
// block stays idle-ready meanwhile and a following item waits at its end
// for the register to free.
// Reset clears position, velocity, the velocity window and the rest flag,
// and loads the default register values.
// Depends on rbls_pkg, rbls_if, rbls_mul and rbls_win.
module rigid_body_linear_step #(
  parameter int REST_FRAMES = rbls_pkg::REST_FRAMES_DEF
) (
  input logic          clk,
  input logic          rst,
  rbls_cfg_if.sink     cfg,
  rbls_tick_if.sink    tick,
  rbls_result_if.source result
);

  localparam int FW = rbls_pkg::FIX_W;
  localparam int PW = rbls_pkg::PROD_W;
  localparam int SW = rbls_pkg::SUM_W;
  localparam int HW = rbls_pkg::HALF_W;
  localparam int RW = $clog2(REST_FRAMES);
  localparam logic [PW-1:0] POS_LIMIT = PW'(rbls_pkg::FIX_MAX);
  localparam logic [PW-1:0] NEG_LIMIT = PW'(48'h8000_0000_0000);

  // Magnitude of a signed value as an unsigned word
  function automatic logic [FW-1:0] mag(rbls_pkg::fix_t v);
    logic [FW-1:0] u;
    u = v;
    return v[FW-1] ? (~u + 1'b1) : u;
  endfunction

  // Saturating signed add
  function automatic rbls_pkg::fix_t sat_add(rbls_pkg::fix_t x, rbls_pkg::fix_t y);
    logic signed [FW:0] s;
    s = (FW + 1)'(x) + (FW + 1)'(y);
    if (s[FW] != s[FW-1]) begin
      return s[FW] ? rbls_pkg::FIX_MIN : rbls_pkg::FIX_MAX;
    end
    return s[FW-1:0];
  endfunction

  // Apply sign to a shifted magnitude and saturate
  function automatic rbls_pkg::fix_t to_fix(logic [PW-1:0] q, logic neg);
    if (neg) begin
      if (q > NEG_LIMIT) begin
        return rbls_pkg::FIX_MIN;
      end
      return rbls_pkg::fix_t'(~q[FW-1:0] + 1'b1);
    end
    if (q > POS_LIMIT) begin
      return rbls_pkg::FIX_MAX;
    end
    return rbls_pkg::fix_t'(q[FW-1:0]);
  endfunction

  // Configuration registers
  logic                           grav_en;
  logic                           movable;
  logic [FW-1:0]                  inv_mass;
  logic [rbls_pkg::DAMP_W-1:0]    damping;
  logic [rbls_pkg::THR_W-1:0]     rest_thr;
  rbls_pkg::vec_t                 start_pos;

  // Body state and item registers
  rbls_pkg::state_t state;
  rbls_pkg::state_t state_next;
  logic [1:0]       comp;
  logic [RW-1:0]    row;
  logic             pending;
  rbls_pkg::vec_t   pos;
  rbls_pkg::vec_t   vel;
  rbls_pkg::vec_t   frc;
  rbls_pkg::fix_t   acc;
  logic [rbls_pkg::DT_W-1:0] dt;
  logic             rest_flag;
  logic             still;
  logic [SW-1:0]    sum;
  logic             big;

  // Output register
  logic           out_valid;
  rbls_pkg::vec_t out_pos;
  rbls_pkg::vec_t out_vel;
  logic           out_rest;

  // Shared units
  logic                 mul_start;
  rbls_pkg::mul_req_t   mul_req;
  logic [PW-1:0]        prod;
  logic                 mul_done;
  logic                 mul_neg;
  logic                 win_clear;
  logic                 win_push;
  logic                 win_rd;
  rbls_pkg::vec_t       win_row;

  // Derived values
  logic                 tick_acc;
  logic                 slot_free;
  logic [PW-1:0]        q;
  rbls_pkg::fix_t       term;
  logic [FW-1:0]        sq_mag;
  logic [SW-1:0]        sum_next;
  logic                 big_next;
  logic                 row_fail;

  rbls_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .req   (mul_req),
    .prod  (prod),
    .done  (mul_done)
  );

  rbls_win #(
    .ROWS (REST_FRAMES)
  ) u_win (
    .clk      (clk),
    .rst      (rst),
    .clear    (win_clear),
    .push     (win_push),
    .push_row (vel),
    .rd_en    (win_rd),
    .rd_addr  (row),
    .rd_row   (win_row)
  );

  assign cfg.ready = 1'b1;
  assign tick_acc  = tick.valid & tick.ready;
  assign slot_free = ~out_valid | result.ready;

  // Scale the product to Q15.32 for the current operation
  always_comb begin
    case (state)
      rbls_pkg::ST_DAMP: q = prod >> rbls_pkg::DAMP_FRAC;
      rbls_pkg::ST_ACC:  q = prod >> rbls_pkg::IMASS_FRAC;
      default:           q = prod >> rbls_pkg::DT_FRAC;
    endcase
  end
  assign term = to_fix(q, mul_neg);

  // Rest test of one window component
  assign sq_mag   = mag(win_row[comp]);
  assign sum_next = sum + SW'(prod[2*HW-1:0]);
  assign big_next = big | (|sq_mag[FW-1:HW]);
  assign row_fail = big_next | (sum_next > SW'(rest_thr));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rbls_pkg::ST_IDLE: begin
        if (tick_acc) begin
          state_next = (tick.cmd == rbls_pkg::CMD_RESTART) ? rbls_pkg::ST_EMIT
                                                           : rbls_pkg::ST_DAMP;
        end
      end
      rbls_pkg::ST_DAMP: begin
        if (mul_done && comp == 2'd2) begin
          state_next = movable ? rbls_pkg::ST_ACC : rbls_pkg::ST_FINISH;
        end
      end
      rbls_pkg::ST_ACC: begin
        if (mul_done) begin
          state_next = rbls_pkg::ST_DVEL;
        end
      end
      rbls_pkg::ST_DVEL: begin
        if (mul_done) begin
          state_next = rbls_pkg::ST_DPOS;
        end
      end
      rbls_pkg::ST_DPOS: begin
        if (mul_done) begin
          state_next = (comp == 2'd2) ? rbls_pkg::ST_PUSH : rbls_pkg::ST_ACC;
        end
      end
      rbls_pkg::ST_PUSH:   state_next = rbls_pkg::ST_CHK_RD;
      rbls_pkg::ST_CHK_RD: state_next = rbls_pkg::ST_CHK_SQ;
      rbls_pkg::ST_CHK_SQ: begin
        if (mul_done && comp == 2'd2) begin
          state_next = (row_fail || row == RW'(REST_FRAMES - 1)) ? rbls_pkg::ST_FINISH
                                                                 : rbls_pkg::ST_CHK_RD;
        end
      end
      rbls_pkg::ST_FINISH: state_next = rbls_pkg::ST_EMIT;
      rbls_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_next = rbls_pkg::ST_IDLE;
        end
      end
      default: state_next = rbls_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and multiplier operands
  always_comb begin
    tick.ready = 1'b0;
    mul_start  = 1'b0;
    mul_neg    = 1'b0;
    mul_req    = '0;
    win_clear  = 1'b0;
    win_push   = 1'b0;
    win_rd     = 1'b0;
    case (state)
      rbls_pkg::ST_IDLE: begin
        tick.ready = 1'b1;
        win_clear  = tick.valid & (tick.cmd == rbls_pkg::CMD_RESTART);
      end
      rbls_pkg::ST_DAMP: begin
        mul_start       = ~pending;
        mul_neg         = vel[comp][FW-1];
        mul_req.a       = mag(vel[comp]);
        mul_req.b       = FW'(damping);
        mul_req.short_b = 1'b1;
      end
      rbls_pkg::ST_ACC: begin
        mul_start = ~pending;
        mul_neg   = frc[comp][FW-1];
        mul_req.a = mag(frc[comp]);
        mul_req.b = inv_mass;
      end
      rbls_pkg::ST_DVEL: begin
        mul_start       = ~pending;
        mul_neg         = acc[FW-1];
        mul_req.a       = mag(acc);
        mul_req.b       = FW'(dt);
        mul_req.short_b = 1'b1;
      end
      rbls_pkg::ST_DPOS: begin
        mul_start       = ~pending;
        mul_neg         = vel[comp][FW-1];
        mul_req.a       = mag(vel[comp]);
        mul_req.b       = FW'(dt);
        mul_req.short_b = 1'b1;
      end
      rbls_pkg::ST_PUSH:   win_push = 1'b1;
      rbls_pkg::ST_CHK_RD: win_rd = 1'b1;
      rbls_pkg::ST_CHK_SQ: begin
        mul_start        = ~pending;
        mul_req.a        = FW'(sq_mag[HW-1:0]);
        mul_req.b        = FW'(sq_mag[HW-1:0]);
        mul_req.short_ab = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State register and multiplier handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rbls_pkg::ST_IDLE;
      pending <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start) begin
        pending <= 1'b1;
      end else if (mul_done) begin
        pending <= 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grav_en   <= 1'b1;
      movable   <= 1'b1;
      inv_mass  <= rbls_pkg::INV_MASS_RST;
      damping   <= rbls_pkg::DAMP_RST;
      rest_thr  <= rbls_pkg::THR_RST;
      start_pos <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (rbls_pkg::cfg_reg_t'(cfg.index))
        rbls_pkg::REG_GRAVITY_ENABLE: grav_en <= cfg.data[0];
        rbls_pkg::REG_MOVABLE:        movable <= cfg.data[0];
        rbls_pkg::REG_INVERSE_MASS:   inv_mass <= cfg.data[FW-1:0];
        rbls_pkg::REG_DAMPING:        damping <= cfg.data[rbls_pkg::DAMP_W-1:0];
        rbls_pkg::REG_REST_THRESHOLD: rest_thr <= cfg.data[rbls_pkg::THR_W-1:0];
        rbls_pkg::REG_START_X:        start_pos[0] <= cfg.data[FW-1:0];
        rbls_pkg::REG_START_Y:        start_pos[1] <= cfg.data[FW-1:0];
        rbls_pkg::REG_START_Z:        start_pos[2] <= cfg.data[FW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Body state: position, velocity and rest flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      vel       <= '0;
      rest_flag <= 1'b0;
    end else begin
      case (state)
        rbls_pkg::ST_IDLE: begin
          if (tick_acc && tick.cmd == rbls_pkg::CMD_RESTART) begin
            pos       <= start_pos;
            vel       <= '0;
            rest_flag <= 1'b0;
          end
        end
        rbls_pkg::ST_DAMP: begin
          if (mul_done) begin
            vel[comp] <= term;
          end
        end
        rbls_pkg::ST_DVEL: begin
          if (mul_done) begin
            vel[comp] <= sat_add(vel[comp], term);
          end
        end
        rbls_pkg::ST_DPOS: begin
          if (mul_done) begin
            pos[comp] <= sat_add(pos[comp], term);
          end
        end
        rbls_pkg::ST_FINISH: begin
          if (movable) begin
            rest_flag <= still;
            if (still) begin
              vel <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item registers, component and row counters, rest test accumulators
  always_ff @(posedge clk) begin
    case (state)
      rbls_pkg::ST_IDLE: begin
        comp <= 2'd0;
        if (tick_acc) begin
          frc[0] <= tick.force_x;
          frc[1] <= tick.force_y;
          frc[2] <= tick.force_z;
          dt     <= tick.dt_ms;
        end
      end
      rbls_pkg::ST_DAMP: begin
        if (mul_done) begin
          comp <= (comp == 2'd2) ? 2'd0 : comp + 2'd1;
        end
      end
      rbls_pkg::ST_ACC: begin
        if (mul_done) begin
          acc <= (comp == 2'd1 && grav_en) ? sat_add(term, rbls_pkg::GRAVITY_Y) : term;
        end
      end
      rbls_pkg::ST_DPOS: begin
        if (mul_done) begin
          comp <= (comp == 2'd2) ? 2'd0 : comp + 2'd1;
        end
      end
      rbls_pkg::ST_PUSH: begin
        still <= 1'b1;
        row   <= '0;
        comp  <= 2'd0;
      end
      rbls_pkg::ST_CHK_RD: begin
        sum <= '0;
        big <= 1'b0;
      end
      rbls_pkg::ST_CHK_SQ: begin
        if (mul_done) begin
          sum <= sum_next;
          big <= big_next;
          if (comp == 2'd2) begin
            comp <= 2'd0;
            row  <= row + 1'b1;
            if (row_fail) begin
              still <= 1'b0;
            end
          end else begin
            comp <= comp + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load when free, drop on transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rbls_pkg::ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rbls_pkg::ST_EMIT && slot_free) begin
      out_pos  <= pos;
      out_vel  <= vel;
      out_rest <= rest_flag;
    end
  end

  assign result.valid   = out_valid;
  assign result.pos_x   = out_pos[0];
  assign result.pos_y   = out_pos[1];
  assign result.pos_z   = out_pos[2];
  assign result.vel_x   = out_vel[0];
  assign result.vel_y   = out_vel[1];
  assign result.vel_z   = out_vel[2];
  assign result.at_rest = out_rest;

endmodule
